// File: sv/vss_pkg.sv
// Shared types and constants for the vector spring smoother.
package vss_pkg;

    localparam int unsigned DIV_REM_W = 50;
    localparam int unsigned DIV_NUM_W = 49;
    localparam int unsigned STEP_W = 6;

    localparam logic [STEP_W-1:0] DIV_STEPS_VEL = 6'd49;
    localparam logic [STEP_W-1:0] DIV_STEPS_LIM = 6'd31;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd32;

    localparam logic [1:0] CFG_SPRING_RATE = 2'd0;
    localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;

    localparam logic [15:0] SPRING_RATE_RESET = 16'd256;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WW,
        ST_K,
        ST_N2,
        ST_S,
        ST_SREG,
        ST_PULL,
        ST_NUM,
        ST_DIV,
        ST_SQ,
        ST_ACC,
        ST_CHK,
        ST_CMP,
        ST_SQRT,
        ST_LMUL,
        ST_LDIV0,
        ST_LDIV,
        ST_POS,
        ST_PADD,
        ST_OUT
    } vss_state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

// File: sv/vss_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module vss_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vss_pkg::div_ctl_t                 ctl,
    input  logic [vss_pkg::DIV_REM_W-1:0]     rem_init,
    input  logic [vss_pkg::DIV_NUM_W-1:0]     numer,
    input  logic [vss_pkg::DIV_REM_W-1:0]     divisor,
    output logic                              done,
    output logic [vss_pkg::DIV_NUM_W-1:0]     quot
);

    logic                             busy_reg;
    logic [vss_pkg::STEP_W-1:0]       cnt_reg;
    logic [vss_pkg::DIV_REM_W-1:0]    rem_reg;
    logic [vss_pkg::DIV_REM_W-1:0]    dvs_reg;
    logic [vss_pkg::DIV_NUM_W-1:0]    num_reg;
    logic [vss_pkg::DIV_NUM_W-1:0]    quot_reg;
    logic [vss_pkg::DIV_REM_W:0]      trial;
    logic [vss_pkg::DIV_REM_W:0]      diff;
    logic                             fits;

    assign trial = {rem_reg, num_reg[vss_pkg::DIV_NUM_W-1]};
    assign diff = trial - {1'b0, dvs_reg};
    assign fits = trial >= {1'b0, dvs_reg};
    assign done = busy_reg && (cnt_reg == '0);
    assign quot = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            cnt_reg <= ctl.steps;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= rem_init;
            num_reg <= numer;
            dvs_reg <= divisor;
            quot_reg <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= fits ? diff[vss_pkg::DIV_REM_W-1:0] : trial[vss_pkg::DIV_REM_W-1:0];
            num_reg <= {num_reg[vss_pkg::DIV_NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[vss_pkg::DIV_NUM_W-2:0], fits};
        end
    end

endmodule

// File: sv/vss_sqrt.sv
// Iterative integer square root, rounded up, two radicand bits per cycle.
module vss_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [32:0] root_ceil
);

    logic                       busy_reg;
    logic [vss_pkg::STEP_W-1:0] cnt_reg;
    logic [63:0]                x_reg;
    logic [33:0]                rem_reg;
    logic [31:0]                root_reg;
    logic [35:0]                trial;
    logic [35:0]                sub;
    logic                       fits;

    assign trial = {rem_reg, x_reg[63:62]};
    assign sub = {2'b00, root_reg, 2'b01};
    assign fits = trial >= sub;
    assign done = busy_reg && (cnt_reg == '0);
    assign root_ceil = {1'b0, root_reg} + {32'b0, (rem_reg != '0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= vss_pkg::SQRT_STEPS;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            x_reg <= {x_reg[61:0], 2'b00};
            rem_reg <= fits ? 34'(trial - sub) : trial[33:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

endmodule

// File: sv/vector_spring_smoother.sv
// Top level of the vector spring smoother: sequencer, shared multiplier and state.
// One transaction is taken at a time: s_tready is high only while the block is idle,
// and the result waits on the master side until it is taken. The run time of an item
// is set mostly by the shared divider, which works out one quotient bit at a time
// (49 bits per axis); when the speed limit clamps, the square root and three more
// divisions of 31 bits are added.
module vector_spring_smoother (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // current_x, current_y, current_z, target_x, target_y, target_z, time_step
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_x, next_y, next_z, speed_x, speed_y, speed_z
    output logic [191:0] m_tdata
);

    vss_pkg::vss_state_t state_reg, state_next;
    logic [1:0]          axis_reg, axis_next;

    logic [15:0]         w_reg;
    logic [30:0]         lim_reg;
    logic signed [31:0]  cur_reg [3];
    logic signed [31:0]  tgt_reg [3];
    logic [15:0]         dt_reg;
    logic [31:0]         k_reg;
    logic [49:0]         s_reg;
    logic [64:0]         prod_reg;
    logic                dneg_reg;
    logic                n1neg_reg;
    logic signed [31:0]  v_reg [3];
    logic signed [31:0]  nv_reg [3];
    logic [31:0]         nxt_reg [3];
    logic [63:0]         sumsq_reg;
    logic [32:0]         len_reg;

    logic [32:0]         mul_a;
    logic [31:0]         mul_b;
    logic [64:0]         mul_p;
    logic [24:0]         n2;
    logic [32:0]         d;
    logic [32:0]         d_mag;
    logic [32:0]         nv_ext;
    logic [31:0]         nv_mag;
    logic [50:0]         v_wide;
    logic [50:0]         p_wide;
    logic [50:0]         n1;
    logic [50:0]         n1_abs;
    logic [48:0]         n1_mag;
    logic [31:0]         q_sat;
    logic [33:0]         pos;
    logic [33:0]         delta;
    logic [31:0]         pos_sat;
    logic [31:0]         lim_q;

    vss_pkg::div_ctl_t   div_ctl;
    logic [vss_pkg::DIV_REM_W-1:0] div_rem_init;
    logic [vss_pkg::DIV_NUM_W-1:0] div_numer;
    logic [vss_pkg::DIV_REM_W-1:0] div_divisor;
    logic                div_done;
    logic [vss_pkg::DIV_NUM_W-1:0] div_quot;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [32:0]         sqrt_root;
    logic                in_acc;
    logic                out_acc;

    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    vss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .numer    (div_numer),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    vss_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sqrt_start),
        .radicand  (sumsq_reg),
        .done      (sqrt_done),
        .root_ceil (sqrt_root)
    );

    assign n2 = 25'd65536 + {1'b0, prod_reg[31:8]};
    assign d = {cur_reg[axis_reg][31], cur_reg[axis_reg]}
             - {tgt_reg[axis_reg][31], tgt_reg[axis_reg]};
    assign d_mag = d[32] ? (~d + 33'd1) : d;
    assign nv_ext = {nv_reg[axis_reg][31], nv_reg[axis_reg]};
    assign nv_mag = 32'(nv_ext[32] ? (~nv_ext + 33'd1) : nv_ext);
    assign mul_p = {32'b0, mul_a} * {33'b0, mul_b};

    assign v_wide = {{19{v_reg[axis_reg][31]}}, v_reg[axis_reg]};
    assign p_wide = {2'b00, prod_reg[64:16]};
    assign n1 = dneg_reg ? (v_wide + p_wide) : (v_wide - p_wide);
    assign n1_abs = n1[50] ? (~n1 + 51'd1) : n1;
    assign n1_mag = n1_abs[48:0];

    always_comb begin
        if (n1neg_reg) begin
            q_sat = (div_quot > 49'h0_8000_0000) ? 32'h8000_0000 : (~div_quot[31:0] + 32'd1);
        end else begin
            q_sat = (div_quot > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
        end
    end

    assign lim_q = nv_reg[axis_reg][31] ? (~{1'b0, div_quot[30:0]} + 32'd1)
                                        : {1'b0, div_quot[30:0]};
    assign delta = nv_reg[axis_reg][31] ? (~{2'b00, prod_reg[47:16]} + 34'd1)
                                        : {2'b00, prod_reg[47:16]};
    assign pos = {{2{cur_reg[axis_reg][31]}}, cur_reg[axis_reg]} + delta;

    always_comb begin
        if (pos[33] && !pos[31]) begin
            pos_sat = 32'h8000_0000;
        end else if (!pos[33] && pos[31]) begin
            pos_sat = 32'h7FFF_FFFF;
        end else begin
            pos_sat = pos[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        case (state_reg)
            vss_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = vss_pkg::ST_WW;
                    axis_next = 2'd0;
                end
            end
            vss_pkg::ST_WW:   state_next = vss_pkg::ST_K;
            vss_pkg::ST_K:    state_next = vss_pkg::ST_N2;
            vss_pkg::ST_N2:   state_next = vss_pkg::ST_S;
            vss_pkg::ST_S:    state_next = vss_pkg::ST_SREG;
            vss_pkg::ST_SREG: state_next = vss_pkg::ST_PULL;
            vss_pkg::ST_PULL: state_next = vss_pkg::ST_NUM;
            vss_pkg::ST_NUM:  state_next = vss_pkg::ST_DIV;
            vss_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = vss_pkg::ST_SQ;
                end
            end
            vss_pkg::ST_SQ:   state_next = vss_pkg::ST_ACC;
            vss_pkg::ST_ACC: begin
                if (axis_reg == 2'd2) begin
                    state_next = vss_pkg::ST_CHK;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = vss_pkg::ST_PULL;
                end
            end
            vss_pkg::ST_CHK:  state_next = vss_pkg::ST_CMP;
            vss_pkg::ST_CMP: begin
                axis_next = 2'd0;
                if (lim_reg != '0 && sumsq_reg > {2'b00, prod_reg[61:0]}) begin
                    state_next = vss_pkg::ST_SQRT;
                end else begin
                    state_next = vss_pkg::ST_POS;
                end
            end
            vss_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = vss_pkg::ST_LMUL;
                end
            end
            vss_pkg::ST_LMUL:  state_next = vss_pkg::ST_LDIV0;
            vss_pkg::ST_LDIV0: state_next = vss_pkg::ST_LDIV;
            vss_pkg::ST_LDIV: begin
                if (div_done) begin
                    if (axis_reg == 2'd2) begin
                        axis_next = 2'd0;
                        state_next = vss_pkg::ST_POS;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                        state_next = vss_pkg::ST_LMUL;
                    end
                end
            end
            vss_pkg::ST_POS:  state_next = vss_pkg::ST_PADD;
            vss_pkg::ST_PADD: begin
                if (axis_reg == 2'd2) begin
                    state_next = vss_pkg::ST_OUT;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = vss_pkg::ST_POS;
                end
            end
            vss_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = vss_pkg::ST_IDLE;
                end
            end
            default: state_next = vss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_ctl = '0;
        div_rem_init = '0;
        div_numer = '0;
        div_divisor = s_reg;
        sqrt_start = 1'b0;
        case (state_reg)
            vss_pkg::ST_IDLE: s_tready = 1'b1;
            vss_pkg::ST_WW: begin
                mul_a = {17'b0, w_reg};
                mul_b = {16'b0, w_reg};
            end
            vss_pkg::ST_K: begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {16'b0, dt_reg};
            end
            vss_pkg::ST_N2: begin
                mul_a = {17'b0, w_reg};
                mul_b = {16'b0, dt_reg};
            end
            vss_pkg::ST_S: begin
                mul_a = {8'b0, n2};
                mul_b = {7'b0, n2};
            end
            vss_pkg::ST_PULL: begin
                mul_a = d_mag;
                mul_b = k_reg;
            end
            vss_pkg::ST_NUM: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = vss_pkg::DIV_STEPS_VEL;
                div_rem_init = {18'b0, n1_mag[48:17]};
                div_numer = {n1_mag[16:0], 32'b0};
            end
            vss_pkg::ST_SQ: begin
                mul_a = {1'b0, nv_mag};
                mul_b = nv_mag;
            end
            vss_pkg::ST_CHK: begin
                mul_a = {2'b00, lim_reg};
                mul_b = {1'b0, lim_reg};
            end
            vss_pkg::ST_CMP: begin
                sqrt_start = lim_reg != '0 && sumsq_reg > {2'b00, prod_reg[61:0]};
            end
            vss_pkg::ST_LMUL: begin
                mul_a = {1'b0, nv_mag};
                mul_b = {1'b0, lim_reg};
            end
            vss_pkg::ST_LDIV0: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = vss_pkg::DIV_STEPS_LIM;
                div_rem_init = {18'b0, prod_reg[62:31]};
                div_numer = {prod_reg[30:0], 18'b0};
                div_divisor = {17'b0, len_reg};
            end
            vss_pkg::ST_POS: begin
                mul_a = {1'b0, nv_mag};
                mul_b = {16'b0, dt_reg};
            end
            vss_pkg::ST_OUT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vss_pkg::ST_IDLE;
            axis_reg <= 2'd0;
            w_reg <= vss_pkg::SPRING_RATE_RESET;
            lim_reg <= '0;
            v_reg[0] <= '0;
            v_reg[1] <= '0;
            v_reg[2] <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            if (cfg_we && cfg_addr == vss_pkg::CFG_SPRING_RATE) begin
                w_reg <= cfg_wdata[15:0];
            end
            if (cfg_we && cfg_addr == vss_pkg::CFG_SPEED_LIMIT) begin
                lim_reg <= cfg_wdata;
            end
            if (state_reg == vss_pkg::ST_PADD && axis_reg == 2'd2) begin
                v_reg[0] <= nv_reg[0];
                v_reg[1] <= nv_reg[1];
                v_reg[2] <= nv_reg[2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            vss_pkg::ST_IDLE: begin
                if (in_acc) begin
                    cur_reg[0] <= s_tdata[31:0];
                    cur_reg[1] <= s_tdata[63:32];
                    cur_reg[2] <= s_tdata[95:64];
                    tgt_reg[0] <= s_tdata[127:96];
                    tgt_reg[1] <= s_tdata[159:128];
                    tgt_reg[2] <= s_tdata[191:160];
                    dt_reg <= s_tdata[207:192];
                    sumsq_reg <= '0;
                end
            end
            vss_pkg::ST_N2:   k_reg <= prod_reg[47:16];
            vss_pkg::ST_SREG: s_reg <= prod_reg[49:0];
            vss_pkg::ST_PULL: dneg_reg <= d[32];
            vss_pkg::ST_NUM:  n1neg_reg <= n1[50];
            vss_pkg::ST_DIV: begin
                if (div_done) begin
                    nv_reg[axis_reg] <= q_sat;
                end
            end
            vss_pkg::ST_ACC:  sumsq_reg <= sumsq_reg + prod_reg[63:0];
            vss_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    len_reg <= sqrt_root;
                end
            end
            vss_pkg::ST_LDIV: begin
                if (div_done) begin
                    nv_reg[axis_reg] <= lim_q;
                end
            end
            vss_pkg::ST_PADD: nxt_reg[axis_reg] <= pos_sat;
            default: ;
        endcase
    end

    assign m_tdata = {v_reg[2], v_reg[1], v_reg[0], nxt_reg[2], nxt_reg[1], nxt_reg[0]};

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("Input accepted while a result is pending.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready && !m_tvalid)
        else $error("Block not busy after accepting a transaction.");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |=> s_tready && !m_tvalid)
        else $error("Block not idle after delivering a result.");
`endif

endmodule
